FILE: rtl/wgms_pkg.sv
// ----------------------------------------------------------------------------
// Windowed gyro statistics package
// Shared widths, reset values, saturation limits and item kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package wgms_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // Divider: divisor width and width of the quotient that is kept.
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 24;

    localparam int OUT_DATA_W = 96;

    localparam logic [15:0] WINDOW_TICKS_RST = 16'd1000;
    localparam logic [15:0] WINDOW_FULL      = 16'hFFFF;

    localparam logic [DIV_Q_W-1:0] MEAN_POS_LIM = 24'h7FFFFF;
    localparam logic [DIV_Q_W-1:0] MEAN_NEG_LIM = 24'h800000;
    localparam logic [DIV_Q_W-1:0] STD_LIM      = 24'hFFFFFF;

    // Kind of an input item, carried in the low bits of s_axis_tuser.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_SPARE = 2'd3
    } t_action;

endpackage

`default_nettype wire

FILE: rtl/wgms_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add product, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module wgms_mul #(
    parameter int SAMPLE_BITS = wgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*SAMPLE_BITS+15:0] i_a,
    input  logic [SAMPLE_BITS+14:0]   i_b,
    output logic                      o_busy,
    output logic [2*SAMPLE_BITS+29:0] o_product
);

    localparam int A_W   = 2*SAMPLE_BITS + 16;
    localparam int B_W   = SAMPLE_BITS + 15;
    localparam int P_W   = 2*SAMPLE_BITS + 30;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;
    logic [P_W-1:0]   n_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    // Every partial product is bounded by the final one, so the
    // accumulator never needs more bits than the result.
    assign n_acc = {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? P_W'(r_a) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[B_W-2:0], 1'b0};
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_acc;

endmodule

`default_nettype wire

FILE: rtl/wgms_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, with a sticky overflow
// flag for quotient bits above the kept width, and the final remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module wgms_div #(
    parameter int SAMPLE_BITS = wgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [SAMPLE_BITS+24:0]        i_num,
    input  logic [wgms_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_busy,
    output logic [wgms_pkg::DIV_Q_W-1:0]   o_quot,
    output logic                           o_ovf,
    output logic [wgms_pkg::DIV_DEN_W-1:0] o_rem
);

    import wgms_pkg::*;

    localparam int NUM_W = SAMPLE_BITS + 25;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]     r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_quot;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;

    logic [DIV_DEN_W:0]   t_sh;
    logic [DIV_DEN_W:0]   t_diff;
    logic                 t_borrow;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        t_sh               = {r_rem, r_num[NUM_W-1]};
        {t_borrow, t_diff} = {1'b0, t_sh} - {2'b00, r_den};
        // Either way the new remainder is below the divisor.
        n_rem = t_borrow ? t_sh[DIV_DEN_W-1:0] : t_diff[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[DIV_Q_W-2:0], ~t_borrow};
            r_ovf  <= r_ovf | r_quot[DIV_Q_W-1];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/wgms_sqrt.sv
// ----------------------------------------------------------------------------
// Serial square root
// Restoring integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wgms_sqrt #(
    parameter int SAMPLE_BITS = wgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*SAMPLE_BITS+45:0] i_value,
    output logic                      o_busy,
    output logic [SAMPLE_BITS+22:0]   o_root
);

    localparam int V_W   = 2*SAMPLE_BITS + 46;
    localparam int RT_W  = SAMPLE_BITS + 23;
    localparam int RM_W  = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [V_W-1:0]   r_val;
    logic [RM_W-1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [RM_W-1:0]  t_sh;
    logic [RM_W-1:0]  t_diff;
    logic             t_borrow;

    // The remainder never exceeds twice the root, so its top two bits are
    // always clear before the shift.
    always_comb begin
        t_sh               = {r_rem[RM_W-3:0], r_val[V_W-1 -: 2]};
        {t_borrow, t_diff} = {1'b0, t_sh} - {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[V_W-3:0], 2'b00};
            r_rem  <= t_borrow ? t_sh : t_diff;
            r_root <= {r_root[RT_W-2:0], ~t_borrow};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: rtl/windowed_gyro_mean_stddev_top.sv
// ----------------------------------------------------------------------------
// Windowed gyro mean and standard deviation
// Accumulates gyro samples over a tick window and reports mean and spread.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is a 1 ms tick carrying a gyro sample and a temperature,
// or a start or stop command (s_axis_tuser). While measuring, every tick
// with the sensor ready counts and, while the window is not full, is
// added to the window sums. When the elapsed tick count is a multiple of
// the window length one record leaves on the m_axis channel and the
// window is cleared. The window length is written through the cfg
// channel, which is always ready. A tick runs the serial multiplier for
// the sample square and the serial divider that checks the window
// boundary. A tick that closes a window with samples in it then runs the
// divider and multiplier together, the multiplier again, the square root
// and the divider again, one after another.
// The result sits in an output register: new items are taken while it
// waits, and a stalled receiver only holds the block when the next record
// is ready. Reset stops measuring, clears the sums and sets the window to
// 1000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_gyro_mean_stddev_top #(
    parameter int SAMPLE_BITS = wgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration: window length in ticks.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [15:0]                           i_cfg_data,
    // tdata: gyro_z, temperature[11:0], sensor_ready, zero padding.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+20)/8)*8-1:0]     s_axis_tdata,
    // tuser: action[1:0], temp_valid.
    input  logic [2:0]                            s_axis_tuser,
    // tdata: elapsed_ticks[31:0], temp_out[11:0], gyro_mean[23:0],
    // gyro_std[23:0], zero padding.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [wgms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // tuser: temp_out_valid.
    output logic [0:0]                            m_axis_tuser
);

    import wgms_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 16;
    localparam int SQ_W  = 2*SAMPLE_BITS + 16;
    localparam int MAG_W = SAMPLE_BITS + 15;
    localparam int P_W   = 2*SAMPLE_BITS + 30;
    localparam int V_W   = 2*SAMPLE_BITS + 46;
    localparam int RT_W  = SAMPLE_BITS + 23;
    localparam int NUM_W = SAMPLE_BITS + 25;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_WAIT,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_STD_GO,
        S_STD_WAIT,
        S_OUT
    } t_state;

    t_state r_state;

    logic [15:0]             r_window_ticks;
    logic                    r_measuring;
    logic [31:0]             r_elapsed;
    logic [15:0]             r_window_n;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_add_sq;
    logic [11:0]             r_temp;
    logic                    r_temp_valid;
    logic [DIV_Q_W-1:0]      r_mean;
    logic [DIV_Q_W-1:0]      r_std;
    logic [P_W-1:0]          r_prod;

    logic                    r_out_valid;
    logic [31:0]             r_out_elapsed;
    logic [11:0]             r_out_temp;
    logic                    r_out_tv;
    logic [DIV_Q_W-1:0]      r_out_mean;
    logic [DIV_Q_W-1:0]      r_out_std;

    // Input fields.
    logic [SAMPLE_BITS-1:0]  s_gyro;
    logic [11:0]             s_temp;
    logic                    s_ready;
    t_action                 s_action;
    logic                    s_tv;
    logic                    in_acc;
    logic                    tick_go;
    logic [SAMPLE_BITS-1:0]  g_mag;

    logic [SUM_W-1:0]        s_abs;
    logic [MAG_W-1:0]        s_mag;
    logic [15:0]             w_eff;
    logic [31:0]             n_elapsed;

    // Shared serial units.
    logic                    mul_start;
    logic [SQ_W-1:0]         mul_a;
    logic [MAG_W-1:0]        mul_b;
    logic                    mul_busy;
    logic [P_W-1:0]          mul_product;

    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DIV_DEN_W-1:0]    div_den;
    logic                    div_busy;
    logic [DIV_Q_W-1:0]      div_quot;
    logic                    div_ovf;
    logic [DIV_DEN_W-1:0]    div_rem;

    logic                    sqrt_start;
    logic                    sqrt_busy;
    logic [RT_W-1:0]         sqrt_root;

    logic [DIV_Q_W-1:0]      mean_sat;
    logic [P_W-1:0]          var_diff;
    logic                    var_borrow;
    logic                    out_free;

    assign s_gyro   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_temp   = s_axis_tdata[SAMPLE_BITS+11:SAMPLE_BITS];
    assign s_ready  = s_axis_tdata[SAMPLE_BITS+12];
    assign s_action = t_action'(s_axis_tuser[1:0]);
    assign s_tv     = s_axis_tuser[2];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign tick_go       = in_acc && (s_action == ACT_TICK) && r_measuring && s_ready;

    assign g_mag     = s_gyro[SAMPLE_BITS-1] ? -s_gyro : s_gyro;
    assign s_abs     = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign s_mag     = s_abs[MAG_W-1:0];
    assign w_eff     = (r_window_ticks == 16'd0) ? 16'd1 : r_window_ticks;
    assign n_elapsed = r_elapsed + 32'd1;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign {var_borrow, var_diff} = {1'b0, r_prod} - {1'b0, mul_product};

    // Mean rounds half away from zero and saturates to the Q16.8 range.
    always_comb begin
        if (r_sum[SUM_W-1]) begin
            mean_sat = (div_ovf || div_quot > MEAN_NEG_LIM) ? MEAN_NEG_LIM : -div_quot;
        end else begin
            mean_sat = (div_ovf || div_quot[DIV_Q_W-1]) ? MEAN_POS_LIM : div_quot;
        end
    end

    always_comb begin
        mul_start  = 1'b0;
        mul_a      = SQ_W'(g_mag);
        mul_b      = MAG_W'(g_mag);
        div_start  = 1'b0;
        div_num    = NUM_W'(n_elapsed);
        div_den    = {1'b0, w_eff};
        sqrt_start = 1'b0;
        if (tick_go) begin
            mul_start = 1'b1;
            div_start = 1'b1;
        end
        case (r_state)
            S_MEAN_GO: begin
                mul_start = 1'b1;
                mul_a     = r_sq;
                mul_b     = MAG_W'(r_window_n);
                div_start = 1'b1;
                div_num   = NUM_W'({s_mag, 9'd0}) + NUM_W'(r_window_n);
                div_den   = {r_window_n, 1'b0};
            end
            S_SQR_GO: begin
                mul_start = 1'b1;
                mul_a     = SQ_W'(s_mag);
                mul_b     = s_mag;
            end
            S_ROOT_GO: begin
                sqrt_start = 1'b1;
            end
            S_STD_GO: begin
                div_start = 1'b1;
                div_num   = NUM_W'(sqrt_root);
                div_den   = {1'b0, r_window_n};
            end
            default: begin
            end
        endcase
    end

    wgms_mul #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_busy    (mul_busy),
        .o_product (mul_product)
    );

    wgms_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf),
        .o_rem   (div_rem)
    );

    // The standard deviation is isqrt(65536 * D) / n, with D = n*sq - s*s,
    // which equals the floor of the root of the Q16 variance.
    wgms_sqrt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ({r_prod, 16'd0}),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_ticks <= WINDOW_TICKS_RST;
            r_measuring    <= 1'b0;
            r_elapsed      <= '0;
            r_window_n     <= '0;
            r_sum          <= '0;
            r_sq           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_ticks <= i_cfg_data;
            end
            // In S_OUT the output register is refilled instead of cleared.
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (s_action)
                            ACT_START: begin
                                if (!r_measuring && s_ready) begin
                                    r_measuring <= 1'b1;
                                    r_elapsed   <= '0;
                                    r_window_n  <= '0;
                                    r_sum       <= '0;
                                    r_sq        <= '0;
                                end
                            end
                            ACT_STOP: begin
                                r_measuring <= 1'b0;
                            end
                            ACT_TICK: begin
                                if (tick_go) begin
                                    r_elapsed    <= n_elapsed;
                                    r_temp       <= s_temp;
                                    r_temp_valid <= s_tv;
                                    // A full window still counts time but
                                    // stops accumulating.
                                    if (r_window_n != WINDOW_FULL) begin
                                        r_window_n <= r_window_n + 16'd1;
                                        r_sum      <= r_sum + SUM_W'(signed'(s_gyro));
                                        r_add_sq   <= 1'b1;
                                    end else begin
                                        r_add_sq   <= 1'b0;
                                    end
                                    r_state <= S_TICK_WAIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TICK_WAIT: begin
                    if (!mul_busy && !div_busy) begin
                        if (r_add_sq) begin
                            r_sq <= r_sq + SQ_W'(mul_product);
                        end
                        if (div_rem != '0) begin
                            r_state <= S_IDLE;
                        end else if (r_window_n == 16'd0) begin
                            r_mean  <= '0;
                            r_std   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MEAN_GO;
                        end
                    end
                end
                S_MEAN_GO: begin
                    r_state <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT: begin
                    if (!mul_busy && !div_busy) begin
                        r_mean  <= mean_sat;
                        r_prod  <= mul_product;
                        r_state <= S_SQR_GO;
                    end
                end
                S_SQR_GO: begin
                    r_state <= S_SQR_WAIT;
                end
                S_SQR_WAIT: begin
                    if (!mul_busy) begin
                        if (var_borrow) begin
                            r_std   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_prod  <= var_diff;
                            r_state <= S_ROOT_GO;
                        end
                    end
                end
                S_ROOT_GO: begin
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (!sqrt_busy) begin
                        r_state <= S_STD_GO;
                    end
                end
                S_STD_GO: begin
                    r_state <= S_STD_WAIT;
                end
                S_STD_WAIT: begin
                    if (!div_busy) begin
                        r_std   <= div_ovf ? STD_LIM : div_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_elapsed <= r_elapsed;
                        r_out_temp    <= r_temp_valid ? r_temp : 12'd0;
                        r_out_tv      <= r_temp_valid;
                        r_out_mean    <= r_mean;
                        r_out_std     <= r_std;
                        r_window_n    <= '0;
                        r_sum         <= '0;
                        r_sq          <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_std, r_out_mean, r_out_temp, r_out_elapsed};
    assign m_axis_tuser  = r_out_tv;

endmodule

`default_nettype wire
